// File: rtl/tlbpt_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the TLB page table translator.
package tlbpt_pkg;
    localparam int VA_W        = 16;
    localparam int OFFSET_W    = 8;
    localparam int PAGE_COUNT  = 256;
    localparam int PAGE_W      = $clog2(PAGE_COUNT);
    localparam int FRAME_W     = 8;
    localparam int TLB_N       = 16;
    localparam int TLB_IDX_W   = $clog2(TLB_N);
    localparam int STAMP_W     = 32;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 16;
    localparam int M_TUSER_W   = 2;
    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_W     = 1;
    localparam int Q_CNT_W     = 2;

    localparam logic MODE_FIFO = 1'b0;
    localparam logic MODE_LRU  = 1'b1;

    typedef struct packed {
        logic [PAGE_W-1:0]   page;
        logic [OFFSET_W-1:0] offset;
        logic [FRAME_W-1:0]  spare;
    } req_t;
endpackage

// File: rtl/tlb_page_table_translator.sv
`timescale 1ns / 1ps
// Top level of the TLB page table translator.
//
//  channel | ports                          | payload
//  input   | s_tvalid s_tready s_tdata[23:0] | virtual_address, free_frame
//  result  | m_tvalid m_tready m_tdata m_tuser | physical_address; tlb_hit, page_fault
//  config  | cfg_valid cfg_ready cfg_data    | replacement_mode
//
// TLB hit: finishes in the lookup state; miss with a free slot or FIFO mode: finishes in the page table state.
// Miss on a full TLB in LRU mode: adds a victim scan over all 16 entries, one stamp compared per cycle.
// A 2-entry request queue lets input be taken while the back end or result stalls.
// Reset clears TLB, page valid bits, access counter; page frames are not cleared.
module tlb_page_table_translator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] virtual_address, [23:16] free_frame
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] physical_address
    output logic [1:0]  m_tuser,   // [0] tlb_hit, [1] page_fault
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);
    logic            mode_reg;
    logic            q_valid, q_pop;
    tlbpt_pkg::req_t q_req;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= tlbpt_pkg::MODE_FIFO;
        end else if (cfg_valid) begin
            mode_reg <= cfg_data;
        end
    end

    tlbpt_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_valid  (q_valid),
        .q_req    (q_req),
        .q_pop    (q_pop)
    );

    tlbpt_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .mode     (mode_reg),
        .q_valid  (q_valid),
        .q_req    (q_req),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );
endmodule

// File: rtl/tlbpt_ram.sv
`timescale 1ns / 1ps
// Generic single write port RAM with registered read.
module tlbpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/tlbpt_front.sv
`timescale 1ns / 1ps
// Front end: accepts requests, splits the address, queues them for the back end.
module tlbpt_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tlbpt_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          q_valid,
    output tlbpt_pkg::req_t               q_req,
    input  logic                          q_pop
);
    tlbpt_pkg::req_t                   slot_reg [tlbpt_pkg::Q_DEPTH];
    logic [tlbpt_pkg::Q_PTR_W-1:0]     wptr_reg, rptr_reg;
    logic [tlbpt_pkg::Q_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [tlbpt_pkg::VA_W-1:0]        va;
    tlbpt_pkg::req_t                   req_in;
    logic                              push, pop;

    assign va            = s_tdata[tlbpt_pkg::VA_W-1:0];
    assign req_in.offset = va[tlbpt_pkg::OFFSET_W-1:0];
    assign req_in.page   = tlbpt_pkg::PAGE_W'(va >> tlbpt_pkg::OFFSET_W);
    assign req_in.spare  = s_tdata[tlbpt_pkg::VA_W +: tlbpt_pkg::FRAME_W];

    assign s_tready = (cnt_reg != tlbpt_pkg::Q_CNT_W'(tlbpt_pkg::Q_DEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign q_req    = slot_reg[rptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= rptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wptr_reg] <= req_in;
        end
    end

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= tlbpt_pkg::Q_CNT_W'(tlbpt_pkg::Q_DEPTH))
        else $error("queue count out of range");
    a_cnt_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("queue count missed a push");
    a_empty_ptr: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == '0) |-> (wptr_reg == rptr_reg))
        else $error("empty queue with unequal pointers");
endmodule

// File: rtl/tlbpt_back.sv
`timescale 1ns / 1ps
// Back end: TLB lookup, page table access, TLB refill and result register.
module tlbpt_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            mode,
    input  logic                            q_valid,
    input  tlbpt_pkg::req_t                 q_req,
    output logic                            q_pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tlbpt_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [tlbpt_pkg::M_TUSER_W-1:0] m_tuser
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOOK = 2'd1;
    localparam logic [1:0] ST_PT   = 2'd2;
    localparam logic [1:0] ST_SCAN = 2'd3;

    localparam int N  = tlbpt_pkg::TLB_N;
    localparam int IW = tlbpt_pkg::TLB_IDX_W;

    logic [1:0]                      state_reg;
    tlbpt_pkg::req_t                 req_reg;
    logic [tlbpt_pkg::PAGE_W-1:0]    tlb_page_reg  [N];
    logic [tlbpt_pkg::FRAME_W-1:0]   tlb_frame_reg [N];
    logic [tlbpt_pkg::STAMP_W-1:0]   tlb_stamp_reg [N];
    logic [N-1:0]                    tlb_valid_reg;
    logic [tlbpt_pkg::PAGE_COUNT-1:0] page_valid_reg;
    logic [tlbpt_pkg::STAMP_W-1:0]   count_reg;
    logic [tlbpt_pkg::FRAME_W-1:0]   frame_reg;
    logic                            fault_reg;
    logic [IW-1:0]                   scan_idx_reg, victim_reg;
    logic [tlbpt_pkg::STAMP_W-1:0]   oldest_reg;
    logic                            out_valid_reg;
    logic [tlbpt_pkg::M_TDATA_W-1:0] out_data_reg;
    logic [tlbpt_pkg::M_TUSER_W-1:0] out_user_reg;

    logic [N-1:0]                    match;
    logic                            hit;
    logic [tlbpt_pkg::FRAME_W-1:0]   hit_frame;
    logic                            pv;
    logic [tlbpt_pkg::FRAME_W-1:0]   rd_frame, pt_frame;
    logic                            full;
    logic [IW-1:0]                   first_empty;
    logic [tlbpt_pkg::STAMP_W-1:0]   age;
    logic                            better, scan_last;
    logic                            ins_en, shift_en, finish, fin_hit, fin_fault;
    logic [IW-1:0]                   ins_idx;
    logic [tlbpt_pkg::FRAME_W-1:0]   ins_frame;

    tlbpt_ram #(.WIDTH(tlbpt_pkg::FRAME_W), .DEPTH(tlbpt_pkg::PAGE_COUNT)) u_page_ram (
        .aclk  (aclk),
        .we    (state_reg == ST_PT && !pv),
        .waddr (req_reg.page),
        .wdata (req_reg.spare),
        .raddr (req_reg.page),
        .rdata (rd_frame)
    );

    assign q_pop    = (state_reg == ST_IDLE) && q_valid && !out_valid_reg;
    assign pv       = page_valid_reg[req_reg.page];
    assign pt_frame = pv ? rd_frame : req_reg.spare;
    assign full     = &tlb_valid_reg;
    assign age      = count_reg - tlb_stamp_reg[scan_idx_reg];
    assign better   = (scan_idx_reg == '0) || (age > oldest_reg);
    assign scan_last = (scan_idx_reg == IW'(N - 1));

    always_comb begin
        match     = '0;
        hit_frame = '0;
        for (int i = 0; i < N; i++) begin
            match[i] = tlb_valid_reg[i] && (tlb_page_reg[i] == req_reg.page);
        end
        for (int i = N - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_frame = tlb_frame_reg[i];
            end
        end
        hit = |match;
        first_empty = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (!tlb_valid_reg[i]) begin
                first_empty = IW'(i);
            end
        end
    end

    always_comb begin
        ins_en    = 1'b0;
        shift_en  = 1'b0;
        finish    = 1'b0;
        fin_hit   = 1'b0;
        fin_fault = 1'b0;
        ins_idx   = first_empty;
        ins_frame = pt_frame;
        unique case (state_reg)
            ST_IDLE: ;
            ST_LOOK: begin
                if (hit) begin
                    finish  = 1'b1;
                    fin_hit = 1'b1;
                end
            end
            ST_PT: begin
                fin_fault = !pv;
                if (!full) begin
                    ins_en = 1'b1;
                    finish = 1'b1;
                end else if (mode == tlbpt_pkg::MODE_FIFO) begin
                    shift_en = 1'b1;
                    finish   = 1'b1;
                end
            end
            ST_SCAN: begin
                ins_frame = frame_reg;
                fin_fault = fault_reg;
                ins_idx   = better ? scan_idx_reg : victim_reg;
                if (scan_last) begin
                    ins_en = 1'b1;
                    finish = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            tlb_valid_reg  <= '0;
            page_valid_reg <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < N; i++) begin
                tlb_page_reg[i]  <= '0;
                tlb_frame_reg[i] <= '0;
                tlb_stamp_reg[i] <= '0;
            end
        end else begin
            if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (finish) begin
                out_valid_reg <= 1'b1;
                count_reg     <= count_reg + 1'b1;
                state_reg     <= ST_IDLE;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_pop) begin
                        state_reg <= ST_LOOK;
                    end
                end
                ST_LOOK: begin
                    for (int i = 0; i < N; i++) begin
                        if (match[i]) begin
                            tlb_stamp_reg[i] <= count_reg;
                        end
                    end
                    if (!hit) begin
                        state_reg <= ST_PT;
                    end
                end
                ST_PT: begin
                    if (!pv) begin
                        page_valid_reg[req_reg.page] <= 1'b1;
                    end
                    if (!finish) begin
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN: ;
                default: state_reg <= ST_IDLE;
            endcase
            if (shift_en) begin
                for (int i = 0; i < N - 1; i++) begin
                    tlb_page_reg[i]  <= tlb_page_reg[i+1];
                    tlb_frame_reg[i] <= tlb_frame_reg[i+1];
                    tlb_stamp_reg[i] <= tlb_stamp_reg[i+1];
                end
                tlb_page_reg[N-1]  <= req_reg.page;
                tlb_frame_reg[N-1] <= pt_frame;
                tlb_stamp_reg[N-1] <= count_reg;
            end
            if (ins_en) begin
                tlb_page_reg[ins_idx]  <= req_reg.page;
                tlb_frame_reg[ins_idx] <= ins_frame;
                tlb_stamp_reg[ins_idx] <= count_reg;
                tlb_valid_reg[ins_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            req_reg <= q_req;
        end
        if (state_reg == ST_PT) begin
            frame_reg    <= pt_frame;
            fault_reg    <= !pv;
            scan_idx_reg <= '0;
        end
        if (state_reg == ST_SCAN) begin
            scan_idx_reg <= scan_idx_reg + 1'b1;
            if (better) begin
                oldest_reg <= age;
                victim_reg <= scan_idx_reg;
            end
        end
        if (finish) begin
            out_data_reg <= {(fin_hit ? hit_frame : ins_frame), req_reg.offset};
            out_user_reg <= {fin_fault, fin_hit};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    a_hit_no_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_user_reg[0] && out_user_reg[1]))
        else $error("hit and fault both set");
    a_scan_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> full)
        else $error("victim scan with empty slot");
    a_fault_maps: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PT && !pv) |=> page_valid_reg[$past(req_reg.page)])
        else $error("faulted page not marked valid");
    a_no_pop_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !out_valid_reg)
        else $error("request taken while result pending");
endmodule
